// ----- src/dnsq_pkg.sv -----
// Shared types, codes and constants for the DNS A-record query responder.
// No dependencies; used by dnsq_parser and dns_a_query_responder_core.
package dnsq_pkg;

	typedef enum logic [2:0] {
		PH_HEADER    = 3'd0,
		PH_LABEL_LEN = 3'd1,
		PH_LABEL_BODY = 3'd2,
		PH_TAIL      = 3'd3,
		PH_SKIP_DONE = 3'd4,
		PH_SKIP_DROP = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       drop;
	} reply_item_t;

	// Configuration register indexes
	localparam logic CFG_ANSWER_ADDRESS = 1'b0;
	localparam logic CFG_MAX_RESPONSE   = 1'b1;

	localparam logic [31:0] ANSWER_ADDRESS_RESET = 32'hC0A8_0101;
	localparam logic [15:0] MAX_RESPONSE_RESET   = 16'd512;

	localparam logic [3:0] HDR_LAST_IDX = 4'd11;
	localparam logic [7:0] FLAGS_HI     = 8'h81;
	localparam logic [7:0] FLAGS_LO     = 8'h80;
	localparam logic [7:0] LABEL_MAX    = 8'd63;
	localparam logic [2:0] TAIL_LEN     = 3'd4;
	localparam int         ANSWER_LEN   = 16;
	localparam logic [3:0] ANSWER_LAST_IDX = 4'(ANSWER_LEN - 1);

	// Fixed answer record: name pointer, type A, class IN, TTL 60, rdlength 4, address
	function automatic logic [7:0] answer_byte(input logic [3:0] idx, input logic [31:0] addr);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'hC0;
			4'd1:    b = 8'h0C;
			4'd3:    b = 8'h01;
			4'd5:    b = 8'h01;
			4'd9:    b = 8'h3C;
			4'd11:   b = 8'h04;
			4'd12:   b = addr[31:24];
			4'd13:   b = addr[23:16];
			4'd14:   b = addr[15:8];
			4'd15:   b = addr[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- src/dnsq_parser.sv -----
// Query parser and reply generator, uses dnsq_pkg: walks header, labels and
// QTYPE/QCLASS; one reply item per cycle with room and the 16-byte answer burst.
module dnsq_parser
	import dnsq_pkg::*;
#(
	parameter int POSITION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        query_byte,
	input  logic              query_last,
	input  logic              room,
	input  logic [31:0]       answer_address,
	input  logic [15:0]       max_response_bytes,
	output logic              push,
	output reply_item_t       item,
	output logic              busy
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	phase_t                   phase_q, phase_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [5:0]               label_q, label_d;
	logic                     cnt_hi_q, cnt_hi_d;
	logic [2:0]               tail_q, tail_d;
	logic                     burst_q, burst_d;
	logic [3:0]               ans_idx_q, ans_idx_d;

	logic       rej, emit, ans_start, fall, too_long;
	logic [7:0] echo;
	logic [16:0] reply_len;

	assign reply_len = 17'(pos_q) + 17'(ANSWER_LEN + 1);
	assign too_long  = (pos_q == POS_MAX) || (reply_len > {1'b0, max_response_bytes});

	// Decode the current byte against the parse phase
	always_comb begin
		rej       = 1'b0;
		fall      = 1'b0;
		ans_start = 1'b0;
		echo      = query_byte;
		case (phase_q)
			PH_HEADER: begin
				fall = 1'b1;
				case (pos_q[3:0])
					4'd0, 4'd1: echo = query_byte;
					4'd2: begin
						echo = FLAGS_HI;
						if (query_byte[7]) begin
							rej  = 1'b1;
							fall = 1'b0;
						end
					end
					4'd3: echo = FLAGS_LO;
					4'd5: begin
						echo = 8'h01;
						if (!cnt_hi_q && query_byte == 8'h00) begin
							rej  = 1'b1;
							fall = 1'b0;
						end
					end
					4'd7:    echo = 8'h01;
					default: echo = 8'h00;
				endcase
			end
			PH_LABEL_LEN: begin
				if (query_byte > LABEL_MAX) rej = 1'b1;
				else fall = 1'b1;
			end
			PH_LABEL_BODY: fall = 1'b1;
			PH_TAIL: begin
				if (tail_q == 3'd1) begin
					if (too_long) rej = 1'b1;
					else ans_start = 1'b1;
				end else begin
					fall = 1'b1;
				end
			end
			default: ;
		endcase
		// A query that ends before the question is complete is rejected
		emit = fall && !query_last;
		if (fall && query_last) rej = 1'b1;
	end

	// Next state
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		label_d   = label_q;
		cnt_hi_d  = cnt_hi_q;
		tail_d    = tail_q;
		burst_d   = burst_q;
		ans_idx_d = ans_idx_q;
		if (burst_q && room) begin
			ans_idx_d = ans_idx_q + 4'd1;
			if (ans_idx_q == ANSWER_LAST_IDX) burst_d = 1'b0;
		end
		if (accept) begin
			case (phase_q)
				PH_HEADER: begin
					if (pos_q[3:0] == 4'd4) cnt_hi_d = (query_byte != 8'h00);
					if (pos_q[3:0] == HDR_LAST_IDX) phase_d = PH_LABEL_LEN;
				end
				PH_LABEL_LEN: begin
					if (query_byte == 8'h00) begin
						tail_d  = TAIL_LEN;
						phase_d = PH_TAIL;
					end else begin
						label_d = query_byte[5:0];
						phase_d = PH_LABEL_BODY;
					end
				end
				PH_LABEL_BODY: begin
					label_d = label_q - 6'd1;
					if (label_q == 6'd1) phase_d = PH_LABEL_LEN;
				end
				PH_TAIL: tail_d = tail_q - 3'd1;
				default: ;
			endcase
			if (emit && pos_q != POS_MAX) pos_d = pos_q + POSITION_BITS'(1);
			if (ans_start) begin
				phase_d   = PH_SKIP_DONE;
				burst_d   = 1'b1;
				ans_idx_d = 4'd0;
			end
			if (rej) phase_d = PH_SKIP_DROP;
			// End of query: start over for the next frame
			if (query_last) begin
				phase_d  = PH_HEADER;
				pos_d    = '0;
				label_d  = '0;
				cnt_hi_d = 1'b0;
				tail_d   = '0;
			end
		end
	end

	// Outputs
	always_comb begin
		push      = 1'b0;
		item.data = echo;
		item.last = 1'b0;
		item.drop = 1'b0;
		if (burst_q) begin
			push      = room;
			item.data = answer_byte(ans_idx_q, answer_address);
			item.last = (ans_idx_q == ANSWER_LAST_IDX);
		end else if (accept) begin
			if (rej) begin
				push      = 1'b1;
				item.data = 8'h00;
				item.last = 1'b1;
				item.drop = 1'b1;
			end else if (emit || ans_start) begin
				push = 1'b1;
			end
		end
	end

	assign busy = burst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= '0;
			label_q   <= '0;
			cnt_hi_q  <= 1'b0;
			tail_q    <= '0;
			burst_q   <= 1'b0;
			ans_idx_q <= '0;
		end else begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			label_q   <= label_d;
			cnt_hi_q  <= cnt_hi_d;
			tail_q    <= tail_d;
			burst_q   <= burst_d;
			ans_idx_q <= ans_idx_d;
		end
	end

endmodule

// ----- src/dns_a_query_responder_core.sv -----
// DNS A-record responder core: configuration registers, parser and a
// two-entry reply buffer. Depends on dnsq_pkg and dnsq_parser.
// A reply item is visible in the cycle after its query byte is accepted.
// One query byte per cycle while the reply buffer has room; after the final QCLASS
// byte the parser's answer counter drives a 16-byte burst with query input stalled.
// Reset (arst_n, async): parser back to the header phase, reply buffer empty,
// answer address 192.168.1.1, maximum reply length 512.
module dns_a_query_responder_core
	import dnsq_pkg::*;
#(
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        query_valid,
	output logic        query_stall,
	input  logic [7:0]  query_byte,
	input  logic        query_last,
	output logic        reply_valid,
	input  logic        reply_stall,
	output logic [7:0]  reply_byte,
	output logic        reply_last,
	output logic        reply_drop,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] answer_address_q;
	logic [15:0] max_response_q;

	reply_item_t buf_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;

	logic        accept, pop, push, room, busy;
	reply_item_t item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_address_q <= ANSWER_ADDRESS_RESET;
			max_response_q   <= MAX_RESPONSE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ANSWER_ADDRESS: answer_address_q <= cfg_data;
				CFG_MAX_RESPONSE:   max_response_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign room        = (count_q != 2'd2);
	assign query_stall = busy || !room;
	assign accept      = query_valid && !query_stall;

	dnsq_parser #(
		.POSITION_BITS(POSITION_BITS)
	) u_parser (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.query_byte         (query_byte),
		.query_last         (query_last),
		.room               (room),
		.answer_address     (answer_address_q),
		.max_response_bytes (max_response_q),
		.push               (push),
		.item               (item),
		.busy               (busy)
	);

	assign reply_valid = (count_q != 2'd0);
	assign pop         = reply_valid && !reply_stall;
	assign reply_byte  = buf_q[rd_ptr_q].data;
	assign reply_last  = buf_q[rd_ptr_q].last;
	assign reply_drop  = buf_q[rd_ptr_q].drop;

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for dns_a_query_responder_core: directed queries from a table,
// then random well-formed, broken and noise queries under several answer settings.
// Depends on dnsq_pkg and the core RTL; replies are checked against an inline predictor.
module testbench
	import dnsq_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int IDLE_PCT = 29;
	localparam int SHOWN_MISMATCHES = 40;

	typedef enum {Q_WELL, Q_BROKEN, Q_NOISE} query_kind_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        typed;
		reply_item_t want;
	} plan_row_t;

	// Header bytes echo or rewrite, so most replies here are fixed; the four tail bytes
	// go through the predictor, and the final one carries the answer burst.
	localparam plan_row_t PLAN [26] = '{
		{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0},
		{8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
		{8'h80, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
		{8'h12, 1'b0, 1'b1, 8'h12, 1'b0, 1'b0},
		{8'h34, 1'b0, 1'b1, 8'h34, 1'b0, 1'b0},
		{8'h7F, 1'b0, 1'b1, 8'h81, 1'b0, 1'b0},
		{8'h00, 1'b0, 1'b1, 8'h80, 1'b0, 1'b0},
		{8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
		{8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
		{8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
		{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0},
		{8'h01, 1'b0, 1'b1, 8'h81, 1'b0, 1'b0},
		{8'hFF, 1'b0, 1'b1, 8'h80, 1'b0, 1'b0},
		{8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
		{8'h01, 1'b0, 1'b1, 8'h01, 1'b0, 1'b0},
		{8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
		{8'hFF, 1'b0, 1'b1, 8'h01, 1'b0, 1'b0},
		{8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
		{8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
		{8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
		{8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
		{8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
		{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		{8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		{8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        query_valid = 1'b0;
	logic        query_stall;
	logic [7:0]  query_byte = 8'h00;
	logic        query_last = 1'b0;
	logic        reply_valid;
	logic        reply_stall = 1'b0;
	logic [7:0]  reply_byte;
	logic        reply_last;
	logic        reply_drop;
	logic        cfg_write = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = 32'h0;

	// Predictor state
	logic [15:0] pos_m;
	phase_t      phase_m;
	logic [5:0]  label_left_m;
	logic        count_hi_m;
	logic [2:0]  tail_left_m;
	logic [31:0] address_m;
	logic [15:0] max_len_m;

	reply_item_t due_replies[$];
	bit          quiet = 1'b0;
	int          bytes_sent = 0;
	int          mismatches = 0;
	int          cycles = 0;

	dns_a_query_responder_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		reply_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
	end

	function automatic void restart_query();
		pos_m = '0;
		phase_m = PH_HEADER;
		label_left_m = '0;
		count_hi_m = 1'b0;
		tail_left_m = '0;
	endfunction

	function automatic void push_reply(input logic [7:0] d, input logic l, input logic dr);
		reply_item_t item;
		item.data = d;
		item.last = l;
		item.drop = dr;
		due_replies.push_back(item);
	endfunction

	function automatic void reject_query(input logic l);
		push_reply(8'h00, 1'b1, 1'b1);
		if (l)
			restart_query();
		else
			phase_m = PH_SKIP_DROP;
	endfunction

	function automatic void predict_reply(input logic [7:0] b, input logic l);
		logic [7:0] echo;
		logic [7:0] rec [16];
		echo = b;
		if (phase_m != PH_HEADER && phase_m != PH_LABEL_LEN && phase_m != PH_LABEL_BODY
				&& phase_m != PH_TAIL) begin
			if (l)
				restart_query();
			return;
		end
		case (phase_m)
			PH_HEADER: begin
				case (pos_m)
					16'd0, 16'd1: echo = b;
					16'd2: begin
						if (b[7]) begin
							reject_query(l);
							return;
						end
						echo = FLAGS_HI;
					end
					16'd3: echo = FLAGS_LO;
					16'd4: begin
						count_hi_m = (b != 8'h00);
						echo = 8'h00;
					end
					16'd5: begin
						if (!count_hi_m && b == 8'h00) begin
							reject_query(l);
							return;
						end
						echo = 8'h01;
					end
					16'd7: echo = 8'h01;
					default: echo = 8'h00;
				endcase
				if (pos_m >= 16'(HDR_LAST_IDX))
					phase_m = PH_LABEL_LEN;
			end
			PH_LABEL_LEN: begin
				if (b > LABEL_MAX) begin
					reject_query(l);
					return;
				end
				if (b == 8'h00) begin
					tail_left_m = TAIL_LEN;
					phase_m = PH_TAIL;
				end else begin
					label_left_m = b[5:0];
					phase_m = PH_LABEL_BODY;
				end
			end
			PH_LABEL_BODY: begin
				label_left_m = label_left_m - 6'd1;
				if (label_left_m == 6'd0)
					phase_m = PH_LABEL_LEN;
			end
			default: begin
				tail_left_m = tail_left_m - 3'd1;
				if (tail_left_m == 3'd0) begin
					// Saturated position or too long a reply drops the frame
					if (pos_m == 16'hFFFF || 32'(pos_m) + 32'd17 > 32'(max_len_m)) begin
						reject_query(l);
						return;
					end
					rec = '{8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
						8'h00, 8'h3C, 8'h00, 8'h04, address_m[31:24], address_m[23:16],
						address_m[15:8], address_m[7:0]};
					push_reply(b, 1'b0, 1'b0);
					for (int i = 0; i < 16; i++)
						push_reply(rec[i], i == 15, 1'b0);
					if (l)
						restart_query();
					else
						phase_m = PH_SKIP_DONE;
					return;
				end
			end
		endcase
		// Query ending inside the question
		if (l) begin
			reject_query(1'b1);
			return;
		end
		push_reply(echo, 1'b0, 1'b0);
		if (pos_m != 16'hFFFF)
			pos_m = pos_m + 16'd1;
	endfunction

	task automatic send_query_byte(input logic [7:0] b, input logic l, input logic typed,
			input reply_item_t want);
		bit taken;
		int depth;
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			query_valid <= 1'b0;
			@(posedge clk);
		end
		query_valid <= 1'b1;
		query_byte <= b;
		query_last <= l;
		// Sample stall mid-cycle; the transaction completes at the next rising edge
		do begin
			@(negedge clk);
			taken = !query_stall;
			@(posedge clk);
		end while (!taken);
		depth = due_replies.size();
		predict_reply(b, l);
		if (typed) begin
			while (due_replies.size() > depth)
				void'(due_replies.pop_back());
			due_replies.push_back(want);
		end
		bytes_sent++;
	endtask

	task automatic wait_drained();
		query_valid <= 1'b0;
		do
			@(posedge clk);
		while (due_replies.size() != 0);
	endtask

	task automatic settle();
		wait_drained();
		repeat (20) @(posedge clk);
	endtask

	task automatic program_answer(input logic [31:0] addr, input logic [15:0] max_len);
		cfg_write <= 1'b1;
		cfg_index <= CFG_ANSWER_ADDRESS;
		cfg_data <= addr;
		@(posedge clk);
		cfg_index <= CFG_MAX_RESPONSE;
		cfg_data <= {16'h0000, max_len};
		@(posedge clk);
		cfg_write <= 1'b0;
		address_m = addr;
		max_len_m = max_len;
	endtask

	task automatic send_query(input query_kind_t kind);
		logic [7:0] q[$];
		int         n;
		int         qend;
		int         len;
		if (kind == Q_NOISE) begin
			n = $urandom_range(1, 20);
			repeat (n) q.push_back(8'($urandom));
		end else begin
			q.push_back(8'($urandom));
			q.push_back(8'($urandom));
			q.push_back(8'($urandom_range(0, 127)));
			q.push_back(8'($urandom));
			case ($urandom_range(0, 3))
				0: begin
					q.push_back(8'h00);
					q.push_back(8'($urandom_range(1, 255)));
				end
				1: begin
					q.push_back(8'($urandom_range(1, 255)));
					q.push_back(8'h00);
				end
				default: begin
					q.push_back(8'($urandom));
					q.push_back(8'($urandom_range(1, 255)));
				end
			endcase
			repeat (6) q.push_back(8'($urandom));
			n = $urandom_range(1, 3);
			repeat (n) begin
				len = ($urandom_range(0, 9) == 0) ? 63 : $urandom_range(1, 8);
				q.push_back(8'(len));
				repeat (len) q.push_back(8'($urandom));
			end
			q.push_back(8'h00);
			repeat (4) q.push_back(8'($urandom));
			qend = q.size() - 1;
			n = $urandom_range(0, 3);
			repeat (n) q.push_back(8'($urandom));
			if (kind == Q_BROKEN) begin
				case ($urandom_range(0, 3))
					0: q[2] = q[2] | 8'h80;
					1: begin
						q[4] = 8'h00;
						q[5] = 8'h00;
					end
					2: q[12] = 8'($urandom_range(64, 255));
					default: begin
						// End the query before QCLASS is complete
						n = $urandom_range(1, qend);
						while (q.size() > n)
							void'(q.pop_back());
					end
				endcase
			end
		end
		for (int i = 0; i < q.size(); i++)
			send_query_byte(q[i], i == q.size() - 1, 1'b0, '0);
	endtask

	task automatic run_random(input int budget);
		int stop;
		int pick;
		stop = bytes_sent + budget;
		while (bytes_sent < stop) begin
			if ($urandom_range(0, 3) == 0)
				wait_drained();
			pick = $urandom_range(0, 9);
			if (pick < 6)
				send_query(Q_WELL);
			else if (pick < 9)
				send_query(Q_BROKEN);
			else
				send_query(Q_NOISE);
		end
	endtask

	always @(negedge clk) begin
		reply_item_t want;
		if (arst_n && reply_valid && !reply_stall) begin
			if (due_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("%0t: unexpected reply: byte %02h last %b drop %b", $time,
						reply_byte, reply_last, reply_drop);
			end else begin
				want = due_replies.pop_front();
				if (reply_byte !== want.data || reply_last !== want.last
						|| reply_drop !== want.drop) begin
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES) begin
						if (reply_byte !== want.data)
							$display("%0t: reply_byte expected %02h actual %02h", $time,
								want.data, reply_byte);
						if (reply_last !== want.last)
							$display("%0t: reply_last expected %b actual %b", $time,
								want.last, reply_last);
						if (reply_drop !== want.drop)
							$display("%0t: reply_drop expected %b actual %b", $time,
								want.drop, reply_drop);
					end
				end
			end
		end
	end

	initial begin
		address_m = ANSWER_ADDRESS_RESET;
		max_len_m = MAX_RESPONSE_RESET;
		restart_query();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < 26; r++)
			send_query_byte(PLAN[r].data, PLAN[r].last, PLAN[r].typed, PLAN[r].want);

		settle();
		program_answer($urandom, 16'hFFFF);
		quiet = 1'b1;
		run_random(10);
		quiet = 1'b0;

		settle();
		program_answer(32'hFFFF_FFFF, 16'd0);
		run_random(1);

		settle();
		program_answer(32'h0000_0000, 16'($urandom_range(29, 60)));
		run_random(10);

		settle();
		if (mismatches == 0 && due_replies.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
